// ----- design/kms_pkg.sv -----
// Shared types, constants and helper functions for the keyboard mode sequencer.
package kms_pkg;

	localparam int KEY_COUNT = 8;
	localparam int MAX_STEPS = 4;
	localparam int KEY_W = 3;
	localparam int IDX_W = 2;
	localparam int CNT_W = 16;
	localparam int COLOUR_W = 24;
	localparam int STEP_W = 43;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_WORD_0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_WORD_3 = 3'd5;

	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [2:0] STEP_COUNT_RESET = 3'd4;
	localparam logic [STEP_W-1:0] STEP_WORD_0_RESET = 43'd67108866040;
	localparam logic [STEP_W-1:0] STEP_WORD_1_RESET = 43'd67109386241;
	localparam logic [STEP_W-1:0] STEP_WORD_2_RESET = 43'd67108866040;
	localparam logic [STEP_W-1:0] STEP_WORD_3_RESET = 43'd67242557441;

	typedef enum logic [1:0] {
		MODE_MANUAL = 2'd0,
		MODE_GUIDED = 2'd1,
		MODE_FULL   = 2'd2
	} mode_t;

	typedef logic [STEP_W-1:0] step_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]                debounce_ticks;
		logic [2:0]                      step_count;
		step_word_t [MAX_STEPS-1:0]      step_word;
	} cfg_t;

	typedef struct packed {
		logic             on;
		logic [KEY_W-1:0] key;
	} keyed_t;

	typedef struct packed {
		logic                on;
		logic [KEY_W-1:0]    key;
		logic [COLOUR_W-1:0] colour;
	} light_t;

	typedef struct packed {
		light_t light;
		keyed_t pull;
	} step_out_t;

	typedef struct packed {
		logic [1:0] mode;
		light_t     light;
		keyed_t     pull;
		logic       playing;
	} play_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + CNT_W'(1);
	endfunction

	// Lights the step's key and, in full automatic mode, pulls its servo.
	function automatic step_out_t run_step(input step_word_t w, input logic full);
		step_out_t r;
		r = '0;
		if ({1'b0, w[KEY_W-1:0]} < (KEY_W+1)'(KEY_COUNT)) begin
			r.light.on = 1'b1;
			r.light.key = w[KEY_W-1:0];
			r.light.colour = w[KEY_W +: COLOUR_W];
			if (full) begin
				r.pull.on = 1'b1;
				r.pull.key = w[KEY_W-1:0];
			end
		end
		run_step = r;
	endfunction

	function automatic logic [CNT_W-1:0] step_duration(input step_word_t w);
		step_duration = w[KEY_W+COLOUR_W +: CNT_W];
	endfunction

endpackage

// ----- design/kms_keys.sv -----
// Per-key press debounce and tone key selection with lowest-held fallback.
module kms_keys import kms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [KEY_COUNT-1:0] levels,
	input  logic [CNT_W-1:0]     debounce_ticks,
	output keyed_t               sound
);

	logic [KEY_COUNT-1:0] held_q;
	logic [CNT_W-1:0]     since_q [KEY_COUNT];
	keyed_t               sound_q;

	logic [KEY_COUNT-1:0] press;
	logic [KEY_COUNT-1:0] release_hit;
	logic [KEY_COUNT-1:0] held_d;
	logic [KEY_COUNT-1:0] mix;
	logic                 last_hit;
	logic [KEY_W-1:0]     last_key;
	logic                 fb_on;
	logic [KEY_W-1:0]     fb_key;
	keyed_t               sound_d;

	always_comb begin
		last_hit = 1'b0;
		last_key = '0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			press[i] = levels[i] && !held_q[i] && (since_q[i] >= debounce_ticks);
			release_hit[i] = !levels[i] && held_q[i];
			held_d[i] = press[i] ? 1'b1 : (release_hit[i] ? 1'b0 : held_q[i]);
			if (press[i] || release_hit[i]) begin
				last_hit = 1'b1;
				last_key = KEY_W'(i);
			end
		end
		// Keys at or below the last event already carry their new held flag.
		for (int j = 0; j < KEY_COUNT; j++) begin
			mix[j] = (j <= int'(last_key)) ? held_d[j] : held_q[j];
		end
		fb_on = 1'b0;
		fb_key = '0;
		for (int j = KEY_COUNT - 1; j >= 0; j--) begin
			if (mix[j]) begin
				fb_on = 1'b1;
				fb_key = KEY_W'(j);
			end
		end
		sound_d = sound_q;
		if (last_hit) begin
			if (press[last_key]) begin
				sound_d.on = 1'b1;
				sound_d.key = last_key;
			end else begin
				sound_d.on = fb_on;
				sound_d.key = fb_key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			sound_q <= '0;
			for (int i = 0; i < KEY_COUNT; i++) begin
				since_q[i] <= '0;
			end
		end else if (advance) begin
			held_q <= held_d;
			sound_q <= sound_d;
			for (int i = 0; i < KEY_COUNT; i++) begin
				since_q[i] <= press[i] ? CNT_W'(1) : sat_inc(since_q[i]);
			end
		end
	end

	assign sound = sound_q;

endmodule

// ----- design/kms_play.sv -----
// Mode button debounce, mode cycling and step table playback.
module kms_play import kms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       mode_button,
	input  cfg_t       cfg,
	output play_t      play
);

	mode_t            mode_q;
	logic             prev_q;
	logic [CNT_W-1:0] since_q;
	logic             act_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] el_q;
	light_t           light_q;
	keyed_t           pull_q;

	logic             mode_acc;
	mode_t            mode_d;
	logic             act_d;
	logic [IDX_W-1:0] idx_d;
	logic [IDX_W-1:0] idx_next;
	logic [CNT_W-1:0] el_d;
	light_t           light_d;
	keyed_t           pull_d;
	logic             started;
	logic [2:0]       eff_count;
	step_out_t        first_step;
	step_out_t        next_step;

	always_comb begin
		if (cfg.step_count == 3'd0) begin
			eff_count = 3'd1;
		end else if (cfg.step_count > 3'(MAX_STEPS)) begin
			eff_count = 3'(MAX_STEPS);
		end else begin
			eff_count = cfg.step_count;
		end
	end

	always_comb begin
		mode_acc = mode_button && !prev_q && (since_q >= cfg.debounce_ticks);
		mode_d = mode_q;
		act_d = act_q;
		idx_d = idx_q;
		el_d = el_q;
		light_d = light_q;
		pull_d = pull_q;
		started = 1'b0;
		idx_next = idx_q + IDX_W'(1);
		first_step = '0;
		next_step = '0;
		if (mode_acc) begin
			case (mode_q)
				MODE_MANUAL: mode_d = MODE_GUIDED;
				MODE_GUIDED: mode_d = MODE_FULL;
				default:     mode_d = MODE_MANUAL;
			endcase
			light_d = '0;
			pull_d = '0;
			act_d = 1'b0;
			if (mode_d == MODE_GUIDED || mode_d == MODE_FULL) begin
				act_d = 1'b1;
				idx_d = '0;
				first_step = run_step(cfg.step_word[0], mode_d == MODE_FULL);
				light_d = first_step.light;
				pull_d = first_step.pull;
				el_d = '0;
				started = 1'b1;
			end
		end
		if (act_d) begin
			idx_next = idx_d + IDX_W'(1);
			if (el_d >= step_duration(cfg.step_word[idx_d])) begin
				light_d = '0;
				pull_d = '0;
				if ({1'b0, idx_d} + 3'd1 >= eff_count) begin
					act_d = 1'b0;
				end else begin
					next_step = run_step(cfg.step_word[idx_next], mode_d == MODE_FULL);
					idx_d = idx_next;
					light_d = next_step.light;
					pull_d = next_step.pull;
					started = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MANUAL;
			prev_q <= 1'b0;
			since_q <= '0;
			act_q <= 1'b0;
			idx_q <= '0;
			el_q <= '0;
			light_q <= '0;
			pull_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			prev_q <= mode_button;
			since_q <= mode_acc ? CNT_W'(1) : sat_inc(since_q);
			act_q <= act_d;
			idx_q <= idx_d;
			el_q <= started ? CNT_W'(1) : sat_inc(el_q);
			light_q <= light_d;
			pull_q <= pull_d;
		end
	end

	assign play.mode = mode_q;
	assign play.light = light_q;
	assign play.pull = pull_q;
	assign play.playing = act_q;

endmodule

// ----- design/keyboard_mode_sequencer.sv -----
// Top level of the keyboard mode sequencer: handshakes, configuration and result item.
//
//   Channel  Direction  Contents
//   s_*      in         one tick item: mode button level and key levels
//   m_*      out        one result item per tick: mode, tone, LED, servo, playing
//   cfg_*    in         register index and write data
//
// A new item is accepted in every cycle unless a stalled result holds the input register full.
// A result item is offered once its item has passed the input register and then the state
// registers, which also hold the result item.
// Reset clears all state but the input data register and loads the register defaults.
// A stalled result holds the state; the input register takes one item meanwhile.
module keyboard_mode_sequencer import kms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [0] mode_button, [8:1] key_levels, [15:9] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] current_mode, [2] tone_on, [5:3] tone_key, [6] led_on, [9:7] led_key,
	// [33:10] led_colour, [34] servo_on, [37:35] servo_key, [38] playing, [39] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [STEP_W-1:0]     cfg_data
);

	cfg_t                 cfg_q;
	logic                 valid_s1;
	logic                 mode_button_s1;
	logic [KEY_COUNT-1:0] levels_s1;
	logic                 out_valid_q;
	logic                 advance;
	keyed_t               sound;
	play_t                play;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RESET;
			cfg_q.step_count <= STEP_COUNT_RESET;
			cfg_q.step_word[0] <= STEP_WORD_0_RESET;
			cfg_q.step_word[1] <= STEP_WORD_1_RESET;
			cfg_q.step_word[2] <= STEP_WORD_2_RESET;
			cfg_q.step_word[3] <= STEP_WORD_3_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DEBOUNCE) begin
				cfg_q.debounce_ticks <= cfg_data[CNT_W-1:0];
			end else if (cfg_index == REG_STEP_COUNT) begin
				cfg_q.step_count <= cfg_data[2:0];
			end else if (cfg_index >= REG_STEP_WORD_0 && cfg_index <= REG_STEP_WORD_3) begin
				cfg_q.step_word[IDX_W'(cfg_index - REG_STEP_WORD_0)] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_button_s1 <= s_tdata[0];
			levels_s1 <= s_tdata[KEY_COUNT:1];
		end
	end

	kms_keys u_keys (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.levels         (levels_s1),
		.debounce_ticks (cfg_q.debounce_ticks),
		.sound          (sound)
	);

	kms_play u_play (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.mode_button (mode_button_s1),
		.cfg         (cfg_q),
		.play        (play)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, play.playing, play.pull.key, play.pull.on, play.light.colour,
		play.light.key, play.light.on, sound.key, sound.on, play.mode};

	a_playing_not_manual: assert property (@(posedge clk) disable iff (!arst_n)
		play.playing |-> play.mode != MODE_MANUAL)
		else $error("playback active in manual mode");

	a_servo_with_led: assert property (@(posedge clk) disable iff (!arst_n)
		play.pull.on |-> (play.light.on && play.pull.key == play.light.key))
		else $error("servo pulled without its key lit");

	a_servo_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		play.pull.on |-> play.mode == MODE_FULL)
		else $error("servo pulled outside full automatic mode");

	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(m_tdata))
		else $error("result changed without an item advancing");

endmodule

// ----- bench/tick_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the keyboard mode sequencer: tick predictor and result checker.
package tick_scoreboard_pkg;
	import kms_pkg::*;

	typedef struct packed {
		logic                pad;
		logic                playing;
		logic [KEY_W-1:0]    servo_key;
		logic                servo_on;
		logic [COLOUR_W-1:0] led_colour;
		logic [KEY_W-1:0]    led_key;
		logic                led_on;
		logic [KEY_W-1:0]    tone_key;
		logic                tone_on;
		logic [1:0]          mode;
	} tick_result_t;

	class tick_scoreboard;
		cfg_t                regs;
		mode_t               mode;
		logic                mode_prev;
		logic [CNT_W-1:0]    mode_since;
		logic [KEY_COUNT-1:0] held;
		logic [CNT_W-1:0]    key_since [KEY_COUNT];
		logic                playing;
		logic [IDX_W-1:0]    step_idx;
		logic [CNT_W-1:0]    step_age;
		keyed_t              sound;
		light_t              light;
		keyed_t              pull;
		tick_result_t        expected_results [$];
		int unsigned         mismatches;

		function new();
			regs.debounce_ticks = DEBOUNCE_RESET;
			regs.step_count = STEP_COUNT_RESET;
			regs.step_word[0] = STEP_WORD_0_RESET;
			regs.step_word[1] = STEP_WORD_1_RESET;
			regs.step_word[2] = STEP_WORD_2_RESET;
			regs.step_word[3] = STEP_WORD_3_RESET;
			mode = MODE_MANUAL;
			mode_prev = 1'b0;
			mode_since = '0;
			held = '0;
			foreach (key_since[k]) key_since[k] = '0;
			playing = 1'b0;
			step_idx = '0;
			step_age = '0;
			sound = '0;
			light = '0;
			pull = '0;
			mismatches = 0;
		endfunction

		function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function int steps_to_play();
			int c;
			c = int'(regs.step_count);
			if (c < 1) c = 1;
			if (c > MAX_STEPS) c = MAX_STEPS;
			return c;
		endfunction

		function void start_step();
			step_word_t w;
			w = regs.step_word[step_idx];
			light = '0;
			pull = '0;
			if (int'(w[KEY_W-1:0]) < KEY_COUNT) begin
				light.on = 1'b1;
				light.key = w[KEY_W-1:0];
				light.colour = w[KEY_W +: COLOUR_W];
				if (mode == MODE_FULL) begin
					pull.on = 1'b1;
					pull.key = w[KEY_W-1:0];
				end
			end
			step_age = '0;
		endfunction

		function void switch_mode(input mode_t m);
			light = '0;
			pull = '0;
			playing = 1'b0;
			mode = m;
			if (m != MODE_MANUAL) begin
				playing = 1'b1;
				step_idx = '0;
				start_step();
			end
		endfunction

		function void write_register(input logic [CFG_IDX_W-1:0] index, input step_word_t data);
			case (index)
				REG_DEBOUNCE: regs.debounce_ticks = data[CNT_W-1:0];
				REG_STEP_COUNT: regs.step_count = data[2:0];
				default: begin
					if (index >= REG_STEP_WORD_0 && index <= REG_STEP_WORD_3)
						regs.step_word[index - REG_STEP_WORD_0] = data;
				end
			endcase
		endfunction

		function void note_tick(input logic btn, input logic [KEY_COUNT-1:0] levels);
			logic                 mode_hit;
			logic [KEY_COUNT-1:0] key_hit;
			step_word_t           w;
			tick_result_t         r;
			int                   k;
			int                   j;
			mode_hit = 1'b0;
			key_hit = '0;
			if (btn && !mode_prev && mode_since >= regs.debounce_ticks) begin
				case (mode)
					MODE_MANUAL: switch_mode(MODE_GUIDED);
					MODE_GUIDED: switch_mode(MODE_FULL);
					default: switch_mode(MODE_MANUAL);
				endcase
				mode_hit = 1'b1;
			end
			mode_prev = btn;

			// Keys are scanned upward; a release falls back to the lowest key held so far.
			for (k = 0; k < KEY_COUNT; k++) begin
				if (levels[k] && !held[k]) begin
					if (key_since[k] >= regs.debounce_ticks) begin
						held[k] = 1'b1;
						key_hit[k] = 1'b1;
						sound.on = 1'b1;
						sound.key = KEY_W'(k);
					end
				end else if (!levels[k] && held[k]) begin
					held[k] = 1'b0;
					sound = '0;
					for (j = KEY_COUNT - 1; j >= 0; j--) begin
						if (held[j]) begin
							sound.on = 1'b1;
							sound.key = KEY_W'(j);
						end
					end
				end
			end

			if (mode != MODE_MANUAL && playing) begin
				w = regs.step_word[step_idx];
				if (step_age >= w[KEY_W+COLOUR_W +: CNT_W]) begin
					light = '0;
					pull = '0;
					if (int'(step_idx) + 1 >= steps_to_play()) begin
						playing = 1'b0;
					end else begin
						step_idx = step_idx + 1'b1;
						start_step();
					end
				end
			end

			mode_since = mode_hit ? CNT_W'(1) : bump(mode_since);
			for (k = 0; k < KEY_COUNT; k++)
				key_since[k] = key_hit[k] ? CNT_W'(1) : bump(key_since[k]);
			step_age = bump(step_age);

			r = '0;
			r.mode = mode;
			r.tone_on = sound.on;
			r.tone_key = sound.on ? sound.key : '0;
			r.led_on = light.on;
			r.led_key = light.on ? light.key : '0;
			r.led_colour = light.on ? light.colour : '0;
			r.servo_on = pull.on;
			r.servo_key = pull.on ? pull.key : '0;
			r.playing = playing;
			expected_results.push_back(r);
		endfunction

		function void compare_field(input string name, input longint unsigned want,
				input longint unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(input logic [OUT_DATA_W-1:0] data);
			tick_result_t got;
			tick_result_t want;
			got = data;
			if (expected_results.size() == 0) begin
				$error("result item with no expectation waiting: %0h", data);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("current_mode", want.mode, got.mode);
			compare_field("tone_on", want.tone_on, got.tone_on);
			compare_field("tone_key", want.tone_key, got.tone_key);
			compare_field("led_on", want.led_on, got.led_on);
			compare_field("led_key", want.led_key, got.led_key);
			compare_field("led_colour", want.led_colour, got.led_colour);
			compare_field("servo_on", want.servo_on, got.servo_on);
			compare_field("servo_key", want.servo_key, got.servo_key);
			compare_field("playing", want.playing, got.playing);
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction
	endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: drives tick items and register writes into the sequencer and checks each result.
module tb_top;
	import kms_pkg::*;
	import tick_scoreboard_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_STEP_WORD_3 + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_TICKS = 120;
	localparam int IDLE_TICKS = 80;

	typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_pattern_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [STEP_W-1:0]     cfg_data = '0;

	tick_scoreboard sb = new();
	int          burst_left = 0;
	rx_pattern_t rx_pattern = RX_OPEN;
	int          rx_left = 0;
	int          rx_count = 0;

	keyboard_mode_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (s_tvalid && s_tready) sb.note_tick(s_tdata[0], s_tdata[KEY_COUNT:1]);
			if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
		end
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_count++;
		case (rx_pattern)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(0, 1));
			RX_THIRD: m_tready <= (rx_count % 3 == 0);
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	function automatic step_word_t make_step(input logic [KEY_W-1:0] key,
			input logic [COLOUR_W-1:0] colour, input logic [CNT_W-1:0] dur);
		return {dur, colour, key};
	endfunction

	task automatic send_tick(input logic btn, input logic [KEY_COUNT-1:0] levels);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'({levels, btn});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input step_word_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic program_phase(input int ph);
		step_word_t       junk;
		logic [CNT_W-1:0] db;
		logic [2:0]       cnt;
		logic [CNT_W-1:0] dur;
		logic [COLOUR_W-1:0] colour;
		int               i;
		case ($urandom_range(0, 9))
			0: db = '0;
			1: db = CNT_W'(1);
			2, 3, 4: db = CNT_W'($urandom_range(2, 6));
			5, 6, 7: db = CNT_W'($urandom_range(7, 25));
			default: db = CNT_W'($urandom_range(0, 3));
		endcase
		if (ph == 0) db = '0;
		if (ph == 1) db = '1;
		cnt = 3'($urandom_range(0, 7));
		if (ph == 2) cnt = '0;
		if (ph == 3) cnt = '1;
		junk = STEP_W'({$urandom(), $urandom()});
		junk[CNT_W-1:0] = db;
		write_reg(REG_DEBOUNCE, junk);
		junk = STEP_W'({$urandom(), $urandom()});
		junk[2:0] = cnt;
		write_reg(REG_STEP_COUNT, junk);
		for (i = 0; i < MAX_STEPS; i++) begin
			case ($urandom_range(0, 9))
				0, 1: dur = '0;
				2, 3, 4, 5, 6: dur = CNT_W'($urandom_range(1, 8));
				7, 8: dur = CNT_W'($urandom_range(9, 40));
				default: dur = '1;
			endcase
			case ($urandom_range(0, 3))
				0: colour = '0;
				1: colour = '1;
				default: colour = COLOUR_W'($urandom());
			endcase
			write_reg(CFG_IDX_W'(REG_STEP_WORD_0 + i),
				make_step(KEY_W'($urandom_range(0, KEY_COUNT - 1)), colour, dur));
		end
		if (ph == 0 || $urandom_range(0, 2) == 0)
			write_reg(REG_SPARE_LO, STEP_W'({$urandom(), $urandom()}));
		if (ph == 0 || $urandom_range(0, 2) == 0)
			write_reg(REG_SPARE_HI, STEP_W'({$urandom(), $urandom()}));
	endtask

	task automatic play_random(input int count);
		logic                 btn;
		logic [KEY_COUNT-1:0] levels;
		int                   toggle_odds;
		int                   idx;
		int                   n;
		btn = 1'b0;
		levels = '0;
		toggle_odds = $urandom_range(2, 30);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, toggle_odds - 1) == 0) btn = ~btn;
			case ($urandom_range(0, 15))
				0: levels = KEY_COUNT'($urandom());
				1, 2, 3, 4: begin
					idx = $urandom_range(0, KEY_COUNT - 1);
					levels[idx] = ~levels[idx];
				end
				5: levels = '0;
				default: ;
			endcase
			send_tick(btn, levels);
		end
	endtask

	initial begin
		int ph;
		int n;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_DEBOUNCE, '0);
		write_reg(REG_STEP_COUNT, STEP_W'(2));
		write_reg(REG_STEP_WORD_0, make_step('1, '1, '0));
		write_reg(REG_STEP_WORD_0 + 3'd1, make_step('0, '0, CNT_W'(2)));
		write_reg(REG_STEP_WORD_0 + 3'd2, make_step(KEY_W'(3), COLOUR_W'(24'h00FF00), CNT_W'(1)));
		write_reg(REG_STEP_WORD_3, make_step(KEY_W'(5), COLOUR_W'(24'hFF0000), CNT_W'(3)));

		// All keys pressed in one tick, then releases that fall back to the lowest held key.
		send_tick(1'b0, 8'h00);
		send_tick(1'b1, 8'hFF);
		send_tick(1'b1, 8'hFE);
		send_tick(1'b0, 8'h7E);
		send_tick(1'b0, 8'h00);
		send_tick(1'b1, 8'h80);
		send_tick(1'b0, 8'h81);
		send_tick(1'b0, 8'h01);
		send_tick(1'b1, 8'h00);
		send_tick(1'b1, 8'hAA);
		send_tick(1'b0, 8'h55);
		send_tick(1'b1, 8'h55);
		repeat (4) send_tick(1'b0, 8'h55);
		send_tick(1'b1, 8'hAA);
		send_tick(1'b0, 8'hAA);
		send_tick(1'b0, 8'h00);
		send_tick(1'b1, 8'hFF);
		send_tick(1'b0, 8'h00);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_results();
			program_phase(ph);
			play_random((ph == 1) ? PHASE_TICKS / 4 : PHASE_TICKS);
		end

		// Presses at the largest debounce are refused while the counters are short of it.
		wait_results();
		write_reg(REG_DEBOUNCE, '1);
		write_reg(REG_STEP_COUNT, STEP_W'(1));
		write_reg(REG_STEP_WORD_0, make_step(KEY_W'(2), COLOUR_W'(24'h123456), CNT_W'(3)));
		for (n = 0; n < IDLE_TICKS; n++) send_tick(1'b0, 8'h00);
		send_tick(1'b1, 8'hFF);
		send_tick(1'b1, 8'h0F);
		send_tick(1'b0, 8'h00);
		repeat (6) send_tick(1'b0, 8'h00);

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
